[rtl/ppm_byte_stream_decoder_unit_defines.svh]
// assertion macros used by the decoder back end (ppmd_back)
`ifndef PPM_BYTE_STREAM_DECODER_UNIT_DEFINES_SVH
`define PPM_BYTE_STREAM_DECODER_UNIT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define PPMD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("ppmd: same-cycle check failed");

// next-cycle implication, checked outside reset
`define PPMD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("ppmd: next-cycle check failed");

`endif

[rtl/ppmd_pkg.sv]
// ----------------------------------------------------------------------------
// ppmd_pkg
// shared types and constants of the ppm byte stream decoder
// ----------------------------------------------------------------------------
`default_nettype none

package ppmd_pkg;

    localparam logic [7:0]  BYTE_P     = 8'h50;
    localparam logic [7:0]  BYTE_3     = 8'h33;
    localparam logic [7:0]  BYTE_6     = 8'h36;
    localparam logic [7:0]  BYTE_HASH  = 8'h23;
    localparam logic [7:0]  BYTE_LF    = 8'h0A;
    localparam logic [7:0]  BYTE_0     = 8'h30;
    localparam logic [7:0]  BYTE_9     = 8'h39;
    localparam logic [12:0] ACC_LIMIT  = 13'd8191;
    localparam logic [7:0]  FULL_SCALE = 8'd255;

    localparam logic [1:0] KIND_HEADER = 2'd0;
    localparam logic [1:0] KIND_PIXEL  = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    localparam logic [1:0] ERR_MAGIC    = 2'd0;
    localparam logic [1:0] ERR_MAX_BIG  = 2'd1;
    localparam logic [1:0] ERR_MAX_ZERO = 2'd2;
    localparam logic [1:0] ERR_DIM      = 2'd3;

    typedef enum logic [1:0] {
        CMD_HEADER = 2'd0,
        CMD_ERROR  = 2'd1,
        CMD_SAMPLE = 2'd2
    } t_cmd_op;

    typedef struct packed {
        t_cmd_op     op;
        logic [12:0] value;
        logic [12:0] width;
        logic [12:0] height;
        logic        binary;
        logic [7:0]  max;
        logic [1:0]  err;
    } t_cmd;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [12:0] image_width;
        logic [12:0] image_height;
        logic        is_binary;
        logic [1:0]  error_code;
        logic        last_pixel;
    } t_result;

endpackage

`default_nettype wire

[rtl/ppmd_byte_if.sv]
// ----------------------------------------------------------------------------
// ppmd_byte_if
// byte channel into the decoder
// ----------------------------------------------------------------------------
`default_nettype none

interface ppmd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink (input valid, input data_byte, output ready);
endinterface

`default_nettype wire

[rtl/ppmd_pix_if.sv]
// ----------------------------------------------------------------------------
// ppmd_pix_if
// result channel out of the decoder
// ----------------------------------------------------------------------------
`default_nettype none

interface ppmd_pix_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [12:0] image_width;
    logic [12:0] image_height;
    logic        is_binary;
    logic [1:0]  error_code;
    logic        last_pixel;

    modport source (output valid, output kind, output red, output green, output blue,
                    output image_width, output image_height, output is_binary,
                    output error_code, output last_pixel, input ready);
    modport sink (input valid, input kind, input red, input green, input blue,
                  input image_width, input image_height, input is_binary,
                  input error_code, input last_pixel, output ready);
endinterface

`default_nettype wire

[rtl/ppmd_front.sv]
// ----------------------------------------------------------------------------
// ppmd_front
// byte parser: magic check, number scanning, header, error and sample commands
// ----------------------------------------------------------------------------
`default_nettype none

module ppmd_front #(
    parameter int MAX_DIM = 4096
) (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire           i_valid,
    input  wire  [7:0]    i_data,
    output logic          o_ready,
    input  wire           i_full,
    output logic          o_push,
    output ppmd_pkg::t_cmd o_cmd
);

    typedef enum logic [7:0] {
        PH_MAGIC_P = 8'b0000_0001,
        PH_MAGIC_D = 8'b0000_0010,
        PH_WIDTH   = 8'b0000_0100,
        PH_HEIGHT  = 8'b0000_1000,
        PH_MAXV    = 8'b0001_0000,
        PH_TEXT    = 8'b0010_0000,
        PH_RAW     = 8'b0100_0000,
        PH_STOP    = 8'b1000_0000
    } t_phase;

    t_phase      r_phase, n_phase;
    logic        r_binary, n_binary;
    logic [12:0] r_acc, n_acc;
    logic        r_in_num, n_in_num;
    logic        r_in_cmt, n_in_cmt;
    logic [12:0] r_width, n_width;
    logic [12:0] r_height, n_height;

    logic        accept;
    logic        is_digit;
    logic        scanning;
    logic        num_end;
    logic [16:0] acc_wide;
    logic        over_dim;

    assign o_ready  = !i_full;
    assign accept   = i_valid && !i_full;
    assign is_digit = (i_data >= ppmd_pkg::BYTE_0) && (i_data <= ppmd_pkg::BYTE_9);
    assign scanning = (r_phase == PH_WIDTH) || (r_phase == PH_HEIGHT) ||
                      (r_phase == PH_MAXV) || (r_phase == PH_TEXT);
    assign acc_wide = {4'b0, r_acc} * 17'd10 + {13'b0, i_data[3:0]};
    assign over_dim = {4'b0, r_acc} > 17'(MAX_DIM);

    always_comb begin
        n_phase  = r_phase;
        n_binary = r_binary;
        n_acc    = r_acc;
        n_in_num = r_in_num;
        n_in_cmt = r_in_cmt;
        n_width  = r_width;
        n_height = r_height;
        num_end  = 1'b0;
        o_push   = 1'b0;
        o_cmd.op     = ppmd_pkg::CMD_SAMPLE;
        o_cmd.value  = r_acc;
        o_cmd.width  = r_width;
        o_cmd.height = r_height;
        o_cmd.binary = r_binary;
        o_cmd.max    = r_acc[7:0];
        o_cmd.err    = ppmd_pkg::ERR_MAGIC;

        // number scanner with comment skipping
        if (scanning) begin
            if (r_in_cmt) begin
                if (i_data == ppmd_pkg::BYTE_LF) begin
                    n_in_cmt = 1'b0;
                end
            end else if (is_digit) begin
                n_acc    = (acc_wide > {4'b0, ppmd_pkg::ACC_LIMIT}) ?
                           ppmd_pkg::ACC_LIMIT : acc_wide[12:0];
                n_in_num = 1'b1;
            end else begin
                if (i_data == ppmd_pkg::BYTE_HASH) begin
                    n_in_cmt = 1'b1;
                end
                if (r_in_num) begin
                    num_end  = 1'b1;
                    n_acc    = '0;
                    n_in_num = 1'b0;
                end
            end
        end

        unique case (r_phase)
            PH_MAGIC_P: begin
                if (i_data != ppmd_pkg::BYTE_P) begin
                    o_push   = 1'b1;
                    o_cmd.op = ppmd_pkg::CMD_ERROR;
                    o_cmd.err = ppmd_pkg::ERR_MAGIC;
                    n_phase  = PH_STOP;
                end else begin
                    n_phase = PH_MAGIC_D;
                end
            end
            PH_MAGIC_D: begin
                if (i_data == ppmd_pkg::BYTE_3) begin
                    n_binary = 1'b0;
                    n_phase  = PH_WIDTH;
                end else if (i_data == ppmd_pkg::BYTE_6) begin
                    n_binary = 1'b1;
                    n_phase  = PH_WIDTH;
                end else begin
                    o_push    = 1'b1;
                    o_cmd.op  = ppmd_pkg::CMD_ERROR;
                    o_cmd.err = ppmd_pkg::ERR_MAGIC;
                    n_phase   = PH_STOP;
                end
            end
            PH_WIDTH, PH_HEIGHT: begin
                if (num_end) begin
                    if (over_dim) begin
                        o_push    = 1'b1;
                        o_cmd.op  = ppmd_pkg::CMD_ERROR;
                        o_cmd.err = ppmd_pkg::ERR_DIM;
                        n_phase   = PH_STOP;
                    end else if (r_phase == PH_WIDTH) begin
                        n_width = r_acc;
                        n_phase = PH_HEIGHT;
                    end else begin
                        n_height = r_acc;
                        n_phase  = PH_MAXV;
                    end
                end
            end
            PH_MAXV: begin
                if (num_end) begin
                    o_push = 1'b1;
                    if (r_acc > 13'd255) begin
                        o_cmd.op  = ppmd_pkg::CMD_ERROR;
                        o_cmd.err = ppmd_pkg::ERR_MAX_BIG;
                        n_phase   = PH_STOP;
                    end else if (r_acc == '0) begin
                        o_cmd.op  = ppmd_pkg::CMD_ERROR;
                        o_cmd.err = ppmd_pkg::ERR_MAX_ZERO;
                        n_phase   = PH_STOP;
                    end else begin
                        o_cmd.op = ppmd_pkg::CMD_HEADER;
                        n_in_cmt = 1'b0;
                        if (r_width == '0 || r_height == '0) begin
                            n_phase = PH_STOP;
                        end else begin
                            n_phase = r_binary ? PH_RAW : PH_TEXT;
                        end
                    end
                end
            end
            PH_TEXT: begin
                o_push = num_end;
            end
            PH_RAW: begin
                o_push      = 1'b1;
                o_cmd.value = {5'b0, i_data};
            end
            PH_STOP: begin
                o_push = 1'b0;
            end
            default: begin
                n_phase = PH_STOP;
            end
        endcase

        if (!accept) begin
            o_push = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_MAGIC_P;
            r_binary <= 1'b0;
            r_acc    <= '0;
            r_in_num <= 1'b0;
            r_in_cmt <= 1'b0;
            r_width  <= '0;
            r_height <= '0;
        end else if (accept) begin
            r_phase  <= n_phase;
            r_binary <= n_binary;
            r_acc    <= n_acc;
            r_in_num <= n_in_num;
            r_in_cmt <= n_in_cmt;
            r_width  <= n_width;
            r_height <= n_height;
        end
    end

endmodule

`default_nettype wire

[rtl/ppmd_queue.sv]
// ----------------------------------------------------------------------------
// ppmd_queue
// two-entry command queue between parser and scaler
// ----------------------------------------------------------------------------
`default_nettype none

module ppmd_queue (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_push,
    input  ppmd_pkg::t_cmd i_cmd,
    output logic           o_full,
    input  wire            i_pop,
    output ppmd_pkg::t_cmd o_cmd,
    output logic           o_empty
);

    ppmd_pkg::t_cmd r_mem [2];
    logic           r_wp, r_rp;
    logic [1:0]     r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_cmd   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            r_count <= r_count + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

endmodule

`default_nettype wire

[rtl/ppmd_back.sv]
// ----------------------------------------------------------------------------
// ppmd_back
// sample scaler with serial divider, pixel assembly and result register
// ----------------------------------------------------------------------------
`default_nettype none

`include "ppm_byte_stream_decoder_unit_defines.svh"

module ppmd_back (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  ppmd_pkg::t_cmd     i_cmd,
    input  wire                i_empty,
    output logic               o_pop,
    output logic               o_valid,
    input  wire                i_ready,
    output ppmd_pkg::t_result  o_res
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_EMIT = 3'b100
    } t_state;

    t_state             r_state, n_state;
    logic               r_done, n_done;
    logic [7:0]         r_max, n_max;
    logic               r_binary, n_binary;
    logic [23:0]        r_left, n_left;
    logic [1:0]         r_cidx, n_cidx;
    logic [7:0]         r_held0, n_held0;
    logic [7:0]         r_held1, n_held1;
    logic [7:0]         r_blue, n_blue;
    logic [7:0]         r_rem, n_rem;
    logic [7:0]         r_quo, n_quo;
    logic [7:0]         r_num_lo, n_num_lo;
    logic [2:0]         r_cnt, n_cnt;
    logic               r_ov, n_ov;
    ppmd_pkg::t_result  r_out, n_out;

    logic        out_free;
    logic        load;
    logic [25:0] area;
    logic [25:0] area_m1;
    logic [15:0] numer;
    logic [8:0]  trial;
    logic        fits;
    logic        comp_done;
    logic [7:0]  comp_val;

    assign out_free = !r_ov || i_ready;
    assign area     = i_cmd.width * i_cmd.height;
    assign area_m1  = area - 26'd1;
    assign numer    = i_cmd.value[7:0] * ppmd_pkg::FULL_SCALE;
    assign trial    = {r_rem, r_num_lo[7]};
    assign fits     = trial >= {1'b0, r_max};

    always_comb begin
        n_state  = r_state;
        n_done   = r_done;
        n_max    = r_max;
        n_binary = r_binary;
        n_left   = r_left;
        n_cidx   = r_cidx;
        n_held0  = r_held0;
        n_held1  = r_held1;
        n_blue   = r_blue;
        n_rem    = r_rem;
        n_quo    = r_quo;
        n_num_lo = r_num_lo;
        n_cnt    = r_cnt;
        n_ov     = r_ov && !i_ready;
        n_out    = r_out;
        o_pop    = 1'b0;
        load     = 1'b0;
        comp_done = 1'b0;
        comp_val  = ppmd_pkg::FULL_SCALE;

        unique case (r_state)
            ST_IDLE: begin
                if (!i_empty) begin
                    unique case (i_cmd.op)
                        ppmd_pkg::CMD_HEADER: begin
                            if (out_free) begin
                                o_pop    = 1'b1;
                                load     = 1'b1;
                                n_out    = '0;
                                n_out.kind         = ppmd_pkg::KIND_HEADER;
                                n_out.image_width  = i_cmd.width;
                                n_out.image_height = i_cmd.height;
                                n_out.is_binary    = i_cmd.binary;
                                n_max    = i_cmd.max;
                                n_binary = i_cmd.binary;
                                n_cidx   = '0;
                                n_done   = (area == '0);
                                n_left   = (area_m1[25:24] != 2'b00) ? 24'hFF_FFFF :
                                           area_m1[23:0];
                            end
                        end
                        ppmd_pkg::CMD_ERROR: begin
                            if (out_free) begin
                                o_pop  = 1'b1;
                                load   = 1'b1;
                                n_out  = '0;
                                n_out.kind       = ppmd_pkg::KIND_ERROR;
                                n_out.error_code = i_cmd.err;
                                n_done = 1'b1;
                            end
                        end
                        ppmd_pkg::CMD_SAMPLE: begin
                            o_pop = 1'b1;
                            if (!r_done) begin
                                // sample at or above max lands on full scale
                                if (i_cmd.value >= {5'b0, r_max}) begin
                                    comp_done = 1'b1;
                                end else begin
                                    // quotient fits 8 bits, so start from the high byte
                                    n_rem    = numer[15:8];
                                    n_num_lo = numer[7:0];
                                    n_quo    = '0;
                                    n_cnt    = '0;
                                    n_state  = ST_DIV;
                                end
                            end
                        end
                        default: begin
                            o_pop = 1'b1;
                        end
                    endcase
                end
            end
            ST_DIV: begin
                n_rem    = fits ? 8'(trial - {1'b0, r_max}) : trial[7:0];
                n_quo    = {r_quo[6:0], fits};
                n_num_lo = {r_num_lo[6:0], 1'b0};
                n_cnt    = r_cnt + 3'd1;
                if (r_cnt == 3'd7) begin
                    comp_done = 1'b1;
                    comp_val  = {r_quo[6:0], fits};
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    load  = 1'b1;
                    n_out = '0;
                    n_out.kind       = ppmd_pkg::KIND_PIXEL;
                    n_out.red        = r_held0;
                    n_out.green      = r_held1;
                    n_out.blue       = r_blue;
                    n_out.is_binary  = r_binary;
                    n_out.last_pixel = (r_left == '0);
                    if (r_left == '0) begin
                        n_done = 1'b1;
                    end else begin
                        n_left = r_left - 24'd1;
                    end
                    n_cidx  = '0;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // component slotting
        if (comp_done) begin
            priority case (r_cidx)
                2'd0: begin
                    n_held0 = comp_val;
                    n_cidx  = 2'd1;
                    n_state = ST_IDLE;
                end
                2'd1: begin
                    n_held1 = comp_val;
                    n_cidx  = 2'd2;
                    n_state = ST_IDLE;
                end
                default: begin
                    n_blue  = comp_val;
                    n_state = ST_EMIT;
                end
            endcase
        end

        if (load) begin
            n_ov = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_done   <= 1'b0;
            r_max    <= '0;
            r_binary <= 1'b0;
            r_left   <= '0;
            r_cidx   <= '0;
            r_ov     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_done   <= n_done;
            r_max    <= n_max;
            r_binary <= n_binary;
            r_left   <= n_left;
            r_cidx   <= n_cidx;
            r_ov     <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_held0  <= n_held0;
        r_held1  <= n_held1;
        r_blue   <= n_blue;
        r_rem    <= n_rem;
        r_quo    <= n_quo;
        r_num_lo <= n_num_lo;
        r_cnt    <= n_cnt;
        r_out    <= n_out;
    end

    assign o_valid = r_ov;
    assign o_res   = r_out;

    `PPMD_ASSERT_IMP(a_div_rem_below_max, i_clk, i_rst_n, r_state == ST_DIV, r_rem < r_max)
    `PPMD_ASSERT_IMP(a_emit_has_three, i_clk, i_rst_n, r_state == ST_EMIT, r_cidx == 2'd2)
    `PPMD_ASSERT_NEXT(a_last_stops, i_clk, i_rst_n, load && n_out.last_pixel, r_done)

endmodule

`default_nettype wire

[rtl/ppm_byte_stream_decoder_unit.sv]
// ----------------------------------------------------------------------------
// ppm_byte_stream_decoder_unit
// ppm (p3 text / p6 raw) byte stream decoder, top level
// ----------------------------------------------------------------------------
// takes a ppm file one byte per transaction, checks the magic, parses width,
// height and max value (skipping whitespace and '#' comments), then scales
// each pixel component as value*255/max with saturation at 255. it sends one
// header transaction, then one transaction per rgb pixel with last_pixel set
// on the final one; a bad magic, a max of zero or above 255, or a dimension
// above MAX_DIM gives a single error transaction, and all later bytes are
// dropped until reset. the parser takes one byte per cycle while its
// two-entry command queue has room. the scaler is the throughput limit: a
// component below max goes through a restoring divider of 8 steps after it
// is dequeued, and a component at or above max is set to 255 as it is
// dequeued; the scaler takes one component at a time, and a finished pixel
// waits in the emit state until the result register is free. a text file
// needs one byte after its last number before the last pixel comes out.
// ----------------------------------------------------------------------------
`default_nettype none

module ppm_byte_stream_decoder_unit #(
    parameter int MAX_DIM = 4096
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    ppmd_byte_if.sink    i_byte,
    ppmd_pix_if.source   o_pix
);

    // parser to queue
    logic               push;
    logic               full;
    ppmd_pkg::t_cmd     push_cmd;

    // queue to scaler
    logic               pop;
    logic               empty;
    ppmd_pkg::t_cmd     head_cmd;

    // result register
    ppmd_pkg::t_result  res;

    ppmd_front #(
        .MAX_DIM (MAX_DIM)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_byte.valid),
        .i_data  (i_byte.data_byte),
        .o_ready (i_byte.ready),
        .i_full  (full),
        .o_push  (push),
        .o_cmd   (push_cmd)
    );

    ppmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_cmd   (head_cmd),
        .o_empty (empty)
    );

    ppmd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (head_cmd),
        .i_empty (empty),
        .o_pop   (pop),
        .o_valid (o_pix.valid),
        .i_ready (o_pix.ready),
        .o_res   (res)
    );

    // unpack the result register onto the channel
    assign o_pix.kind         = res.kind;
    assign o_pix.red          = res.red;
    assign o_pix.green        = res.green;
    assign o_pix.blue         = res.blue;
    assign o_pix.image_width  = res.image_width;
    assign o_pix.image_height = res.image_height;
    assign o_pix.is_binary    = res.is_binary;
    assign o_pix.error_code   = res.error_code;
    assign o_pix.last_pixel   = res.last_pixel;

endmodule

`default_nettype wire
